// File: rtl/gfpc_pkg.sv
// ----------------------------------------------------------------------------
// gfpc_pkg
// Types, constants and register map shared by the GIF frame compositor.
// ----------------------------------------------------------------------------
`default_nettype none

package gfpc_pkg;

    localparam logic [11:0] MAX_CANVAS_WIDTH  = 12'd2048;
    localparam logic [11:0] MAX_CANVAS_HEIGHT = 12'd2048;
    localparam logic [11:0] FRAME_DIM_MAX     = 12'd2048;
    localparam int          PALETTE_DEPTH     = 256;
    localparam logic [7:0]  ALPHA_OPAQUE      = 8'hff;

    localparam logic OP_PIXEL   = 1'b0;
    localparam logic OP_PALETTE = 1'b1;

    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_CANVAS_WIDTH  = 3'd0;
    localparam logic [2:0] REG_CANVAS_HEIGHT = 3'd1;
    localparam logic [2:0] REG_FRAME_LEFT    = 3'd2;
    localparam logic [2:0] REG_FRAME_TOP     = 3'd3;
    localparam logic [2:0] REG_FRAME_WIDTH   = 3'd4;
    localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd5;
    localparam logic [2:0] REG_TRANSPARENT   = 3'd6;
    localparam logic [2:0] REG_COLOR_COUNT   = 3'd7;

    typedef struct packed {
        logic       op;
        logic [7:0] pixel_index;
        logic [7:0] palette_slot;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } pix_word_t;

    typedef struct packed {
        logic        write_enable;
        logic [21:0] canvas_address;
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic [7:0]  out_alpha;
    } res_word_t;

    typedef struct packed {
        logic [11:0] canvas_width;
        logic [11:0] canvas_height;
        logic [10:0] frame_left;
        logic [10:0] frame_top;
        logic [11:0] frame_width;
        logic [11:0] frame_height;
        logic [8:0]  transparent_index;
        logic [8:0]  color_count;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic        draw;
        logic [11:0] x;
        logic [11:0] y;
        logic [11:0] cw;
        logic [23:0] color;
    } stage_t;

endpackage

`default_nettype wire

// File: rtl/gfpc_cfg.sv
// ----------------------------------------------------------------------------
// gfpc_cfg
// Register bank behind the APB-style configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module gfpc_cfg
    import gfpc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.canvas_width      <= MAX_CANVAS_WIDTH;
            cfg_reg.canvas_height     <= MAX_CANVAS_HEIGHT;
            cfg_reg.frame_left        <= 11'd0;
            cfg_reg.frame_top         <= 11'd0;
            cfg_reg.frame_width       <= 12'd1;
            cfg_reg.frame_height      <= 12'd1;
            cfg_reg.transparent_index <= 9'h1ff;
            cfg_reg.color_count       <= 9'd0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_CANVAS_WIDTH:  cfg_reg.canvas_width      <= pwdata[11:0];
                REG_CANVAS_HEIGHT: cfg_reg.canvas_height     <= pwdata[11:0];
                REG_FRAME_LEFT:    cfg_reg.frame_left        <= pwdata[10:0];
                REG_FRAME_TOP:     cfg_reg.frame_top         <= pwdata[10:0];
                REG_FRAME_WIDTH:   cfg_reg.frame_width       <= pwdata[11:0];
                REG_FRAME_HEIGHT:  cfg_reg.frame_height      <= pwdata[11:0];
                REG_TRANSPARENT:   cfg_reg.transparent_index <= pwdata[8:0];
                REG_COLOR_COUNT:   cfg_reg.color_count       <= pwdata[8:0];
                default:           cfg_reg.color_count       <= cfg_reg.color_count;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_CANVAS_WIDTH:  prdata = {20'd0, cfg_reg.canvas_width};
            REG_CANVAS_HEIGHT: prdata = {20'd0, cfg_reg.canvas_height};
            REG_FRAME_LEFT:    prdata = {21'd0, cfg_reg.frame_left};
            REG_FRAME_TOP:     prdata = {21'd0, cfg_reg.frame_top};
            REG_FRAME_WIDTH:   prdata = {20'd0, cfg_reg.frame_width};
            REG_FRAME_HEIGHT:  prdata = {20'd0, cfg_reg.frame_height};
            REG_TRANSPARENT:   prdata = {23'd0, cfg_reg.transparent_index};
            REG_COLOR_COUNT:   prdata = {23'd0, cfg_reg.color_count};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/gfpc_front.sv
// ----------------------------------------------------------------------------
// gfpc_front
// Raster counters, clipping, transparency test and palette memory stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gfpc_front
    import gfpc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire logic      pixel_valid,
    output logic           pixel_stall,
    input  wire pix_word_t pixel_word,
    input  wire logic      take,
    output stage_t         stage
);

    logic [23:0] palette_mem [PALETTE_DEPTH];

    logic [10:0] column_reg;
    logic [10:0] row_reg;
    logic [10:0] column_next;
    logic [10:0] row_next;
    logic        s1_valid_reg;
    logic        s1_draw_reg;
    logic [11:0] s1_x_reg;
    logic [11:0] s1_y_reg;
    logic [11:0] s1_cw_reg;
    logic [23:0] rd_data_reg;

    logic        load_en;
    logic        accept;
    logic        pix_acc;
    logic [11:0] cw;
    logic [11:0] ch;
    logic [11:0] fw;
    logic [11:0] fh;
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] col_inc;
    logic [11:0] row_inc;
    logic        visible;
    logic        transparent;
    logic        colored;
    logic        draw;

    assign load_en     = !s1_valid_reg || take;
    assign pixel_stall = !load_en;
    assign accept      = pixel_valid && load_en;
    assign pix_acc     = accept && (pixel_word.op == OP_PIXEL);

    assign cw = (cfg.canvas_width  > MAX_CANVAS_WIDTH)  ? MAX_CANVAS_WIDTH  : cfg.canvas_width;
    assign ch = (cfg.canvas_height > MAX_CANVAS_HEIGHT) ? MAX_CANVAS_HEIGHT : cfg.canvas_height;

    always_comb
    begin
        priority if (cfg.frame_width == 12'd0)
            fw = 12'd1;
        else if (cfg.frame_width > FRAME_DIM_MAX)
            fw = FRAME_DIM_MAX;
        else
            fw = cfg.frame_width;
        priority if (cfg.frame_height == 12'd0)
            fh = 12'd1;
        else if (cfg.frame_height > FRAME_DIM_MAX)
            fh = FRAME_DIM_MAX;
        else
            fh = cfg.frame_height;
    end

    assign x       = {1'b0, cfg.frame_left} + {1'b0, column_reg};
    assign y       = {1'b0, cfg.frame_top} + {1'b0, row_reg};
    assign col_inc = {1'b0, column_reg} + 12'd1;
    assign row_inc = {1'b0, row_reg} + 12'd1;

    assign visible     = (x < cw) && (y < ch);
    assign transparent = !cfg.transparent_index[8]
                         && (pixel_word.pixel_index == cfg.transparent_index[7:0]);
    assign colored     = {1'b0, pixel_word.pixel_index} < cfg.color_count;
    assign draw        = visible && !transparent && colored;

    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        if (pix_acc)
        begin
            if (col_inc >= fw)
            begin
                column_next = 11'd0;
                row_next    = (row_inc >= fh) ? 11'd0 : row_inc[10:0];
            end
            else
            begin
                column_next = col_inc[10:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg   <= 11'd0;
            row_reg      <= 11'd0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
            if (load_en)
            begin
                s1_valid_reg <= pixel_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_draw_reg <= pix_acc && draw;
            s1_x_reg    <= x;
            s1_y_reg    <= y;
            s1_cw_reg   <= cw;
        end
    end

    // palette memory, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= palette_mem[pixel_word.pixel_index];
        end
        if (accept && (pixel_word.op == OP_PALETTE))
        begin
            palette_mem[pixel_word.palette_slot] <=
                {pixel_word.in_red, pixel_word.in_green, pixel_word.in_blue};
        end
    end

    assign stage = '{valid: s1_valid_reg, draw: s1_draw_reg, x: s1_x_reg,
                     y: s1_y_reg, cw: s1_cw_reg, color: rd_data_reg};

    a_column_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        pix_acc && (col_inc >= fw) |=> column_reg == 11'd0)
        else $error("column did not wrap at end of frame row");

    a_palette_holds_counters: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (pixel_word.op == OP_PALETTE) |=> $stable(column_reg) && $stable(row_reg))
        else $error("palette word moved the raster counters");

    a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        pix_acc && (col_inc >= fw) && (row_inc >= fh) |=> row_reg == 11'd0)
        else $error("row did not wrap at end of frame");

endmodule

`default_nettype wire

// File: rtl/gfpc_out.sv
// ----------------------------------------------------------------------------
// gfpc_out
// Canvas address multiply-add and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gfpc_out
    import gfpc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire stage_t stage,
    output logic        take,
    output logic        result_valid,
    input  wire logic   result_stall,
    output res_word_t   result_word
);

    logic        result_valid_reg;
    res_word_t   result_reg;
    res_word_t   result_next;
    logic [23:0] prod;
    logic [24:0] sum;

    assign take = !result_valid_reg || !result_stall;

    assign prod = stage.y * stage.cw;
    assign sum  = {1'b0, prod} + {13'd0, stage.x};

    always_comb
    begin
        result_next = '0;
        if (stage.draw)
        begin
            result_next.write_enable   = 1'b1;
            result_next.canvas_address = sum[21:0];
            result_next.out_red        = stage.color[23:16];
            result_next.out_green      = stage.color[15:8];
            result_next.out_blue       = stage.color[7:0];
            result_next.out_alpha      = ALPHA_OPAQUE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            result_valid_reg <= stage.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_word  = result_reg;

    a_written_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.write_enable |-> result_reg.out_alpha == ALPHA_OPAQUE)
        else $error("written pixel is not opaque");

    a_suppressed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.write_enable |->
            result_reg.canvas_address == 22'd0 && result_reg.out_alpha == 8'd0
            && result_reg.out_red == 8'd0 && result_reg.out_green == 8'd0
            && result_reg.out_blue == 8'd0)
        else $error("suppressed word carries data");

    a_stalled_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        stage.valid && !take |=> stage.valid)
        else $error("pending stage word dropped while output stalled");

endmodule

`default_nettype wire

// File: rtl/gif_frame_pixel_compositor.sv
// ----------------------------------------------------------------------------
// gif_frame_pixel_compositor
// Composites palette-index pixels of a GIF frame into canvas colour writes.
// ----------------------------------------------------------------------------
// takes one word per clock while not stalled and gives one result word per word
// taken; the front stage resolves raster position, clipping, transparency and
// the palette memory read, the output stage forms the canvas address with one
// 12x12 multiply-add into the result register; palette writes give a result
// word with write_enable low; the palette must be loaded before any index that
// is drawn; registers must be written by the user only while idle (unenforced)
`default_nettype none

module gif_frame_pixel_compositor
    import gfpc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    input  wire logic              pixel_valid,
    output logic                   pixel_stall,
    input  wire pix_word_t         pixel_word,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output res_word_t              result_word
);

    cfg_t   cfg;
    stage_t stage;
    logic   take;

    gfpc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gfpc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_word  (pixel_word),
        .take        (take),
        .stage       (stage)
    );

    gfpc_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage        (stage),
        .take         (take),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

endmodule

`default_nettype wire
